// File: src/zrf_pkg.sv
package zrf_pkg;

   // Fixed widths of the ports and of the shared multiplier
   localparam int WORD_W        = 32;
   localparam int TERM_W        = 16;
   localparam int PROD_LIMIT_W  = 32;
   localparam int MUL_W         = 32;
   localparam int CSR_IDX_W     = 1;
   localparam int FRAC_BITS_DEF = 16;

   // Tolerance scale of the stop tests (1/10000)
   localparam logic [MUL_W-1:0] TOL_SCALE = 32'd10000;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_LIMIT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRODUCT_LIMIT = 1'b1;

   // Reset values of the configuration registers
   localparam logic [TERM_W-1:0]       TERM_LIMIT_RST    = 16'd256;
   localparam logic [PROD_LIMIT_W-1:0] PRODUCT_LIMIT_RST = 32'd200;

   // Operand pair handed to the shared multiplier
   typedef struct packed {
      logic [MUL_W-1:0] op_a;
      logic [MUL_W-1:0] op_b;
   } mul_req_type;

   // Sequencer states
   typedef enum logic [4:0] {
      S_IDLE,
      S_INIT_DIV,
      S_REM_MUL,
      S_REM_CHK,
      S_HQ,
      S_DIFF,
      S_QK,
      S_ERR_CHK,
      S_DIV,
      S_STEP_A,
      S_STEP_H,
      S_STEP_K,
      S_STEP_P,
      S_CLAMP_MUL,
      S_CLAMP_HI,
      S_CLAMP_LO,
      S_DONE
   } state_type;

endpackage

// File: src/zrf_mul.sv
module zrf_mul (
   input  logic                                clock,
   input  zrf_pkg::mul_req_type                req,
   output logic [2*zrf_pkg::MUL_W-1:0]         product
);

   logic [2*zrf_pkg::MUL_W-1:0] product_ff;
   logic [2*zrf_pkg::MUL_W-1:0] product_in;

   // One full multiply per cycle, result registered
   always_comb begin
      product_in = (2*zrf_pkg::MUL_W)'(req.op_a) * (2*zrf_pkg::MUL_W)'(req.op_b);
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// File: src/zrf_div.sv
module zrf_div #(
   parameter int DIV_W = zrf_pkg::FRAC_BITS_DEF + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output logic [DIV_W-1:0] remainder,
   output logic             busy,
   output logic             done
);

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quot_ff, quot_in;

   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   sub;
   logic             take;
   logic             last;

   // Restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, dvd_ff[DIV_W-1]};
      sub     = trial - {1'b0, dvs_ff};
      take    = trial >= {1'b0, dvs_ff};
      last    = cnt_ff == CNT_W'(DIV_W - 1);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = take ? sub[DIV_W-1:0] : trial[DIV_W-1:0];
         quot_in = {quot_ff[DIV_W-2:0], take};
         dvd_in  = {dvd_ff[DIV_W-2:0], 1'b0};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign quotient  = quot_ff;
   assign remainder = rem_ff;
   assign busy      = busy_ff;
   assign done      = done_ff;

endmodule

// File: src/zoom_ratio_to_fraction_unit.sv
// Zoom ratio to fraction.
// Input channel (req_*): one word carries a zoom factor in unsigned fixed point
// with FRAC_BITS fraction bits; zero counts as one. Result channel (rsp_*): one
// word with numerator and denominator of a small fraction close to the zoom.
// A word is taken at a clock edge where valid is high and stall is low.
// The ratio is expanded as a continued fraction, one Euclid step at a time,
// using one iterative restoring divider and one registered multiplier under a
// sequencer. Each Euclid step runs the stop tests, then a division in the
// divider, then the limit checks; the number of steps is at most about 24
// because terms stay within 16 bits. A zoom below one adds one more division
// at the start. req_stall is high while a word is in work. The finished
// result sits in an output register; a new word is taken while it waits. If
// rsp_stall holds the result, the next word finishes its work and then waits
// for the register. The user must write configuration through csr_* only
// while idle; the block itself does not enforce it. Index 0 is the term
// limit, index 1 the product limit. Synchronous reset clears the sequencer
// and output valid and loads the limits with 256 and 200.
module zoom_ratio_to_fraction_unit #(
   parameter int FRAC_BITS = zrf_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [zrf_pkg::WORD_W-1:0]          req_zoom_fixed,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [zrf_pkg::TERM_W-1:0]          rsp_numerator,
   output logic [zrf_pkg::TERM_W-1:0]          rsp_denominator,
   input  logic                                csr_write,
   input  logic [zrf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [zrf_pkg::PROD_LIMIT_W-1:0]    csr_wdata
);

   localparam int W     = zrf_pkg::WORD_W;
   localparam int TW    = zrf_pkg::TERM_W;
   localparam int MW    = zrf_pkg::MUL_W;
   localparam int PW    = 2 * zrf_pkg::MUL_W;
   localparam int DIV_W = FRAC_BITS + 1;
   localparam logic [W-1:0] ONE       = W'(1) << FRAC_BITS;
   localparam logic [W-1:0] FRAC_MASK = ONE - W'(1);

   zrf_pkg::state_type state_ff, state_in;

   logic [TW-1:0]              term_limit_ff, term_limit_in;
   logic [zrf_pkg::PROD_LIMIT_W-1:0] product_limit_ff, product_limit_in;

   logic [W-1:0]     p_ff, p_in;
   logic [DIV_W-1:0] q_ff, q_in;
   logic [W-1:0]     h_ff, h_in;
   logic [TW-1:0]    k_ff, k_in;
   logic [TW-1:0]    hp_ff, hp_in;
   logic [TW-1:0]    kp_ff, kp_in;
   logic [DIV_W-1:0] base_ff, base_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic             inv_ff, inv_in;
   logic [PW-1:0]    hq_ff, hq_in;
   logic [PW-1:0]    qk_ff, qk_in;
   logic             diff_big_ff, diff_big_in;
   logic [MW-1:0]    diff_lo_ff, diff_lo_in;
   logic [MW:0]      hn_ff, hn_in;
   logic [TW-1:0]    kn_ff, kn_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]    rsp_num_ff, rsp_num_in;
   logic [TW-1:0]    rsp_den_ff, rsp_den_in;

   logic [TW-1:0]    lim;
   logic [W-1:0]     zoom_v;
   logic             req_take;
   logic [PW-1:0]    diff;
   logic [MW:0]      kn_sum;

   zrf_pkg::mul_req_type mul_req;
   logic [PW-1:0]        mul_p;

   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_divisor;
   logic [DIV_W-1:0] div_quot;
   logic [DIV_W-1:0] div_rem;
   logic             div_busy;
   logic             div_done;

   zrf_mul u_mul (
      .clock   (clock),
      .req     (mul_req),
      .product (mul_p)
   );

   zrf_div #(
      .DIV_W (DIV_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quot),
      .remainder (div_rem),
      .busy      (div_busy),
      .done      (div_done)
   );

   // Zero term limit acts as one; zero zoom counts as one
   assign lim      = (term_limit_ff == '0) ? TW'(1) : term_limit_ff;
   assign zoom_v   = (req_zoom_fixed == '0) ? ONE : req_zoom_fixed;
   assign req_stall = state_ff != zrf_pkg::S_IDLE;
   assign req_take  = req_valid && !req_stall;

   // Configuration writes
   always_comb begin
      term_limit_in    = term_limit_ff;
      product_limit_in = product_limit_ff;
      if (csr_write) begin
         unique case (csr_index)
            zrf_pkg::CSR_TERM_LIMIT:    term_limit_in    = csr_wdata[TW-1:0];
            zrf_pkg::CSR_PRODUCT_LIMIT: product_limit_in = csr_wdata;
         endcase
      end
   end

   // Sequencer: next state, datapath updates, unit requests
   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      h_in         = h_ff;
      k_in         = k_ff;
      hp_in        = hp_ff;
      kp_in        = kp_ff;
      base_in      = base_ff;
      rem_in       = rem_ff;
      inv_in       = inv_ff;
      hq_in        = hq_ff;
      qk_in        = qk_ff;
      diff_big_in  = diff_big_ff;
      diff_lo_in   = diff_lo_ff;
      hn_in        = hn_ff;
      kn_in        = kn_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      mul_req      = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      diff   = (hq_ff >= mul_p) ? (hq_ff - mul_p) : (mul_p - hq_ff);
      kn_sum = (MW+1)'(mul_p[MW-1:0]) + (MW+1)'(kp_ff);

      unique case (state_ff)
         zrf_pkg::S_IDLE: begin
            if (req_take) begin
               k_in  = TW'(1);
               hp_in = TW'(1);
               kp_in = '0;
               if (zoom_v < ONE) begin
                  // zoom below one: work on one/zoom
                  inv_in       = 1'b1;
                  p_in         = ONE;
                  q_in         = zoom_v[DIV_W-1:0];
                  base_in      = zoom_v[DIV_W-1:0];
                  div_start    = 1'b1;
                  div_dividend = ONE[DIV_W-1:0];
                  div_divisor  = zoom_v[DIV_W-1:0];
                  state_in     = zrf_pkg::S_INIT_DIV;
               end else begin
                  inv_in   = 1'b0;
                  p_in     = zoom_v;
                  q_in     = ONE[DIV_W-1:0];
                  base_in  = ONE[DIV_W-1:0];
                  h_in     = zoom_v >> FRAC_BITS;
                  rem_in   = DIV_W'(zoom_v & FRAC_MASK);
                  state_in = zrf_pkg::S_REM_MUL;
               end
            end
         end
         zrf_pkg::S_INIT_DIV: begin
            if (div_done) begin
               h_in     = W'(div_quot);
               rem_in   = div_rem;
               state_in = zrf_pkg::S_REM_MUL;
            end
         end
         zrf_pkg::S_REM_MUL: begin
            mul_req.op_a = MW'(rem_ff);
            mul_req.op_b = zrf_pkg::TOL_SCALE;
            state_in     = zrf_pkg::S_REM_CHK;
         end
         zrf_pkg::S_REM_CHK: begin
            // small remainder ends the expansion
            if (mul_p < PW'(base_ff)) begin
               state_in = zrf_pkg::S_CLAMP_MUL;
            end else begin
               mul_req.op_a = h_ff;
               mul_req.op_b = MW'(q_ff);
               state_in     = zrf_pkg::S_HQ;
            end
         end
         zrf_pkg::S_HQ: begin
            hq_in        = mul_p;
            mul_req.op_a = p_ff;
            mul_req.op_b = MW'(k_ff);
            state_in     = zrf_pkg::S_DIFF;
         end
         zrf_pkg::S_DIFF: begin
            // a difference past 32 bits always exceeds q*k after scaling
            diff_big_in  = |diff[PW-1:MW];
            diff_lo_in   = diff[MW-1:0];
            mul_req.op_a = MW'(q_ff);
            mul_req.op_b = MW'(k_ff);
            state_in     = zrf_pkg::S_QK;
         end
         zrf_pkg::S_QK: begin
            qk_in        = mul_p;
            mul_req.op_a = diff_lo_ff;
            mul_req.op_b = zrf_pkg::TOL_SCALE;
            state_in     = zrf_pkg::S_ERR_CHK;
         end
         zrf_pkg::S_ERR_CHK: begin
            if (diff_big_ff || (mul_p > qk_ff)) begin
               div_start    = 1'b1;
               div_dividend = base_ff;
               div_divisor  = rem_ff;
               state_in     = zrf_pkg::S_DIV;
            end else begin
               state_in = zrf_pkg::S_CLAMP_MUL;
            end
         end
         zrf_pkg::S_DIV: begin
            if (div_done) begin
               state_in = zrf_pkg::S_STEP_A;
            end
         end
         zrf_pkg::S_STEP_A: begin
            // a or h above the limit makes the new numerator too large
            if ((W'(div_quot) > W'(lim)) || (h_ff > W'(lim))) begin
               state_in = zrf_pkg::S_CLAMP_MUL;
            end else begin
               mul_req.op_a = MW'(div_quot);
               mul_req.op_b = h_ff;
               state_in     = zrf_pkg::S_STEP_H;
            end
         end
         zrf_pkg::S_STEP_H: begin
            hn_in        = (MW+1)'(mul_p[MW-1:0]) + (MW+1)'(hp_ff);
            mul_req.op_a = MW'(div_quot);
            mul_req.op_b = MW'(k_ff);
            state_in     = zrf_pkg::S_STEP_K;
         end
         zrf_pkg::S_STEP_K: begin
            if ((hn_ff > (MW+1)'(lim)) || (kn_sum > (MW+1)'(lim))) begin
               state_in = zrf_pkg::S_CLAMP_MUL;
            end else begin
               kn_in        = kn_sum[TW-1:0];
               mul_req.op_a = MW'(hn_ff[TW-1:0]);
               mul_req.op_b = MW'(kn_sum[TW-1:0]);
               state_in     = zrf_pkg::S_STEP_P;
            end
         end
         zrf_pkg::S_STEP_P: begin
            if ((hn_ff > (MW+1)'(1)) && (kn_ff > TW'(1)) &&
                (mul_p > PW'(product_limit_ff))) begin
               state_in = zrf_pkg::S_CLAMP_MUL;
            end else begin
               // take the new convergent and move the remainder along
               hp_in    = h_ff[TW-1:0];
               kp_in    = k_ff;
               h_in     = W'(hn_ff[TW-1:0]);
               k_in     = kn_ff;
               base_in  = rem_ff;
               rem_in   = div_rem;
               state_in = zrf_pkg::S_REM_MUL;
            end
         end
         zrf_pkg::S_CLAMP_MUL: begin
            mul_req.op_a = MW'(lim);
            mul_req.op_b = MW'(k_ff);
            state_in     = zrf_pkg::S_CLAMP_HI;
         end
         zrf_pkg::S_CLAMP_HI: begin
            if (PW'(h_ff) > mul_p) begin
               h_in     = W'(lim);
               k_in     = TW'(1);
               state_in = zrf_pkg::S_DONE;
            end else begin
               mul_req.op_a = h_ff;
               mul_req.op_b = MW'(lim);
               state_in     = zrf_pkg::S_CLAMP_LO;
            end
         end
         zrf_pkg::S_CLAMP_LO: begin
            if (mul_p < PW'(k_ff)) begin
               h_in = W'(1);
               k_in = lim;
            end
            state_in = zrf_pkg::S_DONE;
         end
         zrf_pkg::S_DONE: begin
            // load the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = inv_ff ? k_ff : h_ff[TW-1:0];
               rsp_den_in   = inv_ff ? h_ff[TW-1:0] : k_ff;
               state_in     = zrf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = zrf_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= zrf_pkg::S_IDLE;
         rsp_valid_ff     <= 1'b0;
         term_limit_ff    <= zrf_pkg::TERM_LIMIT_RST;
         product_limit_ff <= zrf_pkg::PRODUCT_LIMIT_RST;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         term_limit_ff    <= term_limit_in;
         product_limit_ff <= product_limit_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      q_ff        <= q_in;
      h_ff        <= h_in;
      k_ff        <= k_in;
      hp_ff       <= hp_in;
      kp_ff       <= kp_in;
      base_ff     <= base_in;
      rem_ff      <= rem_in;
      inv_ff      <= inv_in;
      hq_ff       <= hq_in;
      qk_ff       <= qk_in;
      diff_big_ff <= diff_big_in;
      diff_lo_ff  <= diff_lo_in;
      hn_ff       <= hn_in;
      kn_ff       <= kn_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_den_ff  <= rsp_den_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_numerator   = rsp_num_ff;
   assign rsp_denominator = rsp_den_ff;

   // Divider is never restarted while it runs
   a_div_start_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // A Euclid step never divides by a zero remainder
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == zrf_pkg::S_DIV) |-> (rem_ff != '0))
      else $error("division by zero remainder");

   // Divider completion only arrives while the sequencer waits for it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == zrf_pkg::S_DIV) || (state_ff == zrf_pkg::S_INIT_DIV)))
      else $error("divider done outside a wait state");

   // A finished word waits while the output register is held
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == zrf_pkg::S_DONE) && rsp_valid_ff && rsp_stall)
      |=> (state_ff == zrf_pkg::S_DONE))
      else $error("result overwrote a stalled output word");

endmodule
